### rtl/core/u8ld_pkg.sv
// Shared types and byte-class constants of the lenient UTF-8 decoder.
`timescale 1ns / 1ps
package u8ld_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned Held  = 3;
  localparam int unsigned IdxW  = 2;

  localparam logic [ByteW-1:0] Lead2Lo  = 8'hC2;
  localparam logic [ByteW-1:0] Lead2Hi  = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Lo  = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Hi  = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Lo  = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Hi  = 8'hF4;
  localparam logic [ByteW-1:0] ContMask = 8'hC0;
  localparam logic [ByteW-1:0] ContTag  = 8'h80;

  localparam logic [LenW-1:0] LenOne   = 3'd1;
  localparam logic [LenW-1:0] LenTwo   = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour  = 3'd4;

  // Classification of one byte.
  typedef struct packed {
    logic [LenW-1:0] lead_len;  // 1 when the byte is no lead
    logic            is_cont;
    logic            raw;       // byte is 0x80 or above
  } u8ld_class_t;

  // One result item.
  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    logic            raw_fallback;
    logic            run_last;
    logic            text_last;
  } u8ld_res_t;

endpackage

### rtl/core/u8ld_unit.sv
// Shared byte classifier and codepoint assembler.
`timescale 1ns / 1ps
module u8ld_unit import u8ld_pkg::*; (
  input  logic [ByteW-1:0] sel_byte_i,
  input  logic [ByteW-1:0] held0_i,
  input  logic [ByteW-1:0] held1_i,
  input  logic [ByteW-1:0] held2_i,
  input  logic [ByteW-1:0] last_byte_i,
  input  logic [LenW-1:0]  exp_len_i,
  output u8ld_class_t      class_o,
  output logic [CpW-1:0]   code_point_o
);

  always_comb begin
    class_o.is_cont = ((sel_byte_i & ContMask) == ContTag);
    class_o.raw     = sel_byte_i[ByteW-1];
    if (sel_byte_i >= Lead2Lo && sel_byte_i <= Lead2Hi) begin
      class_o.lead_len = LenTwo;
    end else if (sel_byte_i >= Lead3Lo && sel_byte_i <= Lead3Hi) begin
      class_o.lead_len = LenThree;
    end else if (sel_byte_i >= Lead4Lo && sel_byte_i <= Lead4Hi) begin
      class_o.lead_len = LenFour;
    end else begin
      class_o.lead_len = LenOne;
    end
  end

  always_comb begin
    case (exp_len_i)
      LenTwo: begin
        code_point_o = {10'd0, held0_i[4:0], last_byte_i[5:0]};
      end
      LenThree: begin
        code_point_o = {5'd0, held0_i[3:0], held1_i[5:0], last_byte_i[5:0]};
      end
      LenFour: begin
        code_point_o = {held0_i[2:0], held1_i[5:0], held2_i[5:0], last_byte_i[5:0]};
      end
      default: begin
        code_point_o = '0;
      end
    endcase
  end

endmodule

### rtl/core/u8ld_seq.sv
// Sequencer: held-byte store, per-byte decision and replay of held bytes.
`timescale 1ns / 1ps
module u8ld_seq import u8ld_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_eot_i,
  output logic             in_ready_o,
  input  logic             out_free_i,
  output logic             emit_o,
  output u8ld_res_t        res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAKE,
    ST_DRAIN,
    ST_FLUSH
  } state_e;

  state_e           state_q, state_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             eot_q, eot_d;
  logic             cur_lead_q, cur_lead_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]  exp_q, exp_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] held_q [Held];

  logic             held_we;
  logic [IdxW-1:0]  held_wa;
  logic [ByteW-1:0] sel_byte;
  logic             idx_end;
  u8ld_class_t      cls;
  logic [CpW-1:0]   cp;

  u8ld_unit u_unit (
    .sel_byte_i  (sel_byte),
    .held0_i     (held_q[0]),
    .held1_i     (held_q[1]),
    .held2_i     (held_q[2]),
    .last_byte_i (byte_q),
    .exp_len_i   (exp_q),
    .class_o     (cls),
    .code_point_o(cp)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign idx_end    = (idx_q == cnt_q - 2'd1);

  always_comb begin
    state_d    = state_q;
    byte_d     = byte_q;
    eot_d      = eot_q;
    cur_lead_d = cur_lead_q;
    cnt_d      = cnt_q;
    exp_d      = exp_q;
    idx_d      = idx_q;
    held_we    = 1'b0;
    held_wa    = cnt_q;
    emit_o     = 1'b0;
    res_o      = '0;
    sel_byte   = (state_q == ST_TAKE) ? byte_q : held_q[idx_q];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d  = in_byte_i;
          eot_d   = in_eot_i;
          state_d = ST_TAKE;
        end
      end
      ST_TAKE: begin
        if (out_free_i) begin
          idx_d = '0;
          if (cnt_q == '0) begin
            if (cls.lead_len != LenOne) begin
              held_we = 1'b1;
              held_wa = '0;
              cnt_d   = 2'd1;
              exp_d   = cls.lead_len;
              state_d = eot_q ? ST_FLUSH : ST_IDLE;
            end else begin
              emit_o                 = 1'b1;
              res_o.code_point       = {{(CpW-ByteW){1'b0}}, byte_q};
              res_o.seq_length       = LenOne;
              res_o.raw_fallback     = cls.raw;
              res_o.run_last         = 1'b1;
              res_o.text_last        = eot_q;
              state_d                = ST_IDLE;
            end
          end else if (cls.is_cont) begin
            if ({1'b0, cnt_q} + 3'd1 == exp_q) begin
              emit_o             = 1'b1;
              res_o.code_point   = cp;
              res_o.seq_length   = exp_q;
              res_o.raw_fallback = 1'b0;
              res_o.run_last     = 1'b1;
              res_o.text_last    = eot_q;
              cnt_d              = '0;
              exp_d              = '0;
              state_d            = ST_IDLE;
            end else begin
              held_we = 1'b1;
              cnt_d   = cnt_q + 2'd1;
              state_d = eot_q ? ST_FLUSH : ST_IDLE;
            end
          end else begin
            // remember whether the breaking byte will be held as a new lead
            cur_lead_d = (cls.lead_len != LenOne);
            state_d    = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free_i) begin
          emit_o             = 1'b1;
          res_o.code_point   = {{(CpW-ByteW){1'b0}}, held_q[idx_q]};
          res_o.seq_length   = LenOne;
          res_o.raw_fallback = cls.raw;
          res_o.run_last     = idx_end && cur_lead_q && !eot_q;
          res_o.text_last    = 1'b0;
          if (idx_end) begin
            cnt_d   = '0;
            exp_d   = '0;
            state_d = ST_TAKE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free_i) begin
          emit_o             = 1'b1;
          res_o.code_point   = {{(CpW-ByteW){1'b0}}, held_q[idx_q]};
          res_o.seq_length   = LenOne;
          res_o.raw_fallback = cls.raw;
          res_o.run_last     = idx_end;
          res_o.text_last    = idx_end;
          if (idx_end) begin
            cnt_d   = '0;
            exp_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      eot_q      <= 1'b0;
      cur_lead_q <= 1'b0;
      cnt_q      <= '0;
      exp_q      <= '0;
      idx_q      <= '0;
      byte_q     <= '0;
    end else begin
      state_q    <= state_d;
      eot_q      <= eot_d;
      cur_lead_q <= cur_lead_d;
      cnt_q      <= cnt_d;
      exp_q      <= exp_d;
      idx_q      <= idx_d;
      byte_q     <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[held_wa] <= byte_q;
    end
  end

endmodule

### rtl/core/utf8_lenient_decoder.sv
// Top level of the lenient UTF-8 decoder: sequencer plus output register.
//
//  channel | dir | tdata (low bit up)                      | tuser / tlast
//  s_axis  | in  | text_byte[7:0]                          | tlast = end_of_text
//  m_axis  | out | code_point[20:0], seq_length[23:21]     | tuser[0] = raw_fallback,
//          |     |                                         | tuser[1] = run_last,
//          |     |                                         | tlast = text_last
//
// A byte is accepted in ST_IDLE and then decided in ST_TAKE; at end of text the
// held bytes are flushed one by one in ST_FLUSH. A broken sequence replays each
// held byte in ST_DRAIN and then decides the breaking byte again in ST_TAKE; the
// single sequencer and its shared classify/assemble unit set this order.
// s_axis_tready is high only while the sequencer is idle.
// Results sit in an output register; the sequencer holds while it is full and m_axis_tready is low.
// Reset clears the sequencer and the output valid; held bytes need no reset.
`timescale 1ns / 1ps
module utf8_lenient_decoder import u8ld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] seq_length
  output logic [1:0]  m_axis_tuser,   // [0] raw_fallback, [1] run_last
  output logic        m_axis_tlast    // text_last
);

  logic      out_free;
  logic      emit;
  u8ld_res_t res;
  logic      ovalid_q;
  u8ld_res_t ores_q;

  assign out_free = !ovalid_q || m_axis_tready;

  u8ld_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_byte_i (s_axis_tdata),
    .in_eot_i  (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .out_free_i(out_free),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (emit) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ores_q <= res;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {ores_q.seq_length, ores_q.code_point};
  assign m_axis_tuser  = {ores_q.run_last, ores_q.raw_fallback};
  assign m_axis_tlast  = ores_q.text_last;

  // one byte at a time: after a transfer in, the sequencer is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while sequencer busy");

  a_raw_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:21] == LenOne)
    else $error("raw fallback with multi-byte length");

  a_decoded_not_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23:21] != LenOne |->
      !m_axis_tuser[0] && (m_axis_tdata[23:21] == LenTwo ||
      m_axis_tdata[23:21] == LenThree || m_axis_tdata[23:21] == LenFour))
    else $error("bad decoded result");

  a_text_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("text end without run end");

endmodule

### bench/utf8_lenient_decoder_tb.sv
// Self-checking testbench for the lenient UTF-8 decoder: byte stream in, codepoints out.
`timescale 1ns / 1ps
module utf8_lenient_decoder_tb import u8ld_pkg::*;;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  text_item_t  text_q[$];
  u8ld_res_t   cp_expected_q[$];
  u8ld_res_t   cp_burst[$];

  // decoder state mirrored by the predictor
  logic [7:0]  held_bytes[Held];
  int unsigned held_cnt = 0;
  logic [2:0]  want_len = '0;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned texts_ended = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  utf8_lenient_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    if (b >= Lead2Lo && b <= Lead2Hi) return LenTwo;
    if (b >= Lead3Lo && b <= Lead3Hi) return LenThree;
    if (b >= Lead4Lo && b <= Lead4Hi) return LenFour;
    return LenOne;
  endfunction

  function automatic u8ld_res_t lone_byte(input logic [7:0] b);
    u8ld_res_t r;
    r = '0;
    r.code_point   = {13'd0, b};
    r.seq_length   = LenOne;
    r.raw_fallback = b[7];
    return r;
  endfunction

  function automatic void emit_held();
    for (int unsigned i = 0; i < held_cnt; i++) cp_burst.push_back(lone_byte(held_bytes[i]));
    held_cnt = 0;
    want_len = '0;
  endfunction

  function automatic void start_sequence(input logic [7:0] b);
    logic [2:0] len;
    len = lead_length(b);
    if (len != LenOne) begin
      held_bytes[0] = b;
      held_cnt = 1;
      want_len = len;
    end else begin
      cp_burst.push_back(lone_byte(b));
    end
  endfunction

  // Work out the results of one accepted byte and queue them.
  function automatic void predict_codepoints(input logic [7:0] b, input logic eot);
    u8ld_res_t r;
    cp_burst.delete();
    if (held_cnt == 0) begin
      start_sequence(b);
    end else if ((b & ContMask) == ContTag) begin
      if (held_cnt + 1 == want_len) begin
        r = '0;
        r.seq_length = want_len;
        case (want_len)
          LenTwo:   r.code_point = {10'd0, held_bytes[0][4:0], b[5:0]};
          LenThree: r.code_point = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], b[5:0]};
          default:  r.code_point = {held_bytes[0][2:0], held_bytes[1][5:0],
                                    held_bytes[2][5:0], b[5:0]};
        endcase
        cp_burst.push_back(r);
        held_cnt = 0;
        want_len = '0;
      end else begin
        held_bytes[held_cnt] = b;
        held_cnt++;
      end
    end else begin
      // broken sequence: replay held bytes, then retry this byte as a lead
      emit_held();
      start_sequence(b);
    end
    if (eot) emit_held();
    if (cp_burst.size() != 0) begin
      cp_burst[$].run_last = 1'b1;
      cp_burst[$].text_last = eot;
    end
    foreach (cp_burst[i]) cp_expected_q.push_back(cp_burst[i]);
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      error_cnt++;
    end
  endfunction

  // byte driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= text_q[0].text_byte;
          s_axis_tlast  <= text_q[0].end_of_text;
          s_axis_tvalid <= 1'b1;
          void'(text_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin
    u8ld_res_t got;
    u8ld_res_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_codepoints(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
        if (s_axis_tlast) texts_ended++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.code_point   = m_axis_tdata[20:0];
        got.seq_length   = m_axis_tdata[23:21];
        got.raw_fallback = m_axis_tuser[0];
        got.run_last     = m_axis_tuser[1];
        got.text_last    = m_axis_tlast;
        results_seen++;
        if (cp_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got cp 0x%0h len %0d",
                   $time, got.code_point, got.seq_length);
          error_cnt++;
        end else begin
          want = cp_expected_q.pop_front();
          check_field("code_point", want.code_point, got.code_point);
          check_field("seq_length", want.seq_length, got.seq_length);
          check_field("raw_fallback", want.raw_fallback, got.raw_fallback);
          check_field("run_last", want.run_last, got.run_last);
          check_field("text_last", want.text_last, got.text_last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, cp_expected_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.text_byte   = b;
    it.end_of_text = eot;
    text_q.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [7:0] rand_cont();
    return ContTag | 8'($urandom_range(63));
  endfunction

  function automatic logic rand_eot();
    return ($urandom_range(15) == 0);
  endfunction

  // Mostly well-formed sequences with random payload; some broken ones and noise.
  task automatic add_random_text(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    int unsigned conts;
    logic [7:0]  lead;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        add_byte(8'($urandom_range(127)), rand_eot());
      end else if (pick < 78) begin
        case ($urandom_range(2))
          0:       lead = 8'($urandom_range(Lead2Lo, Lead2Hi));
          1:       lead = 8'($urandom_range(Lead3Lo, Lead3Hi));
          default: lead = 8'($urandom_range(Lead4Lo, Lead4Hi));
        endcase
        add_byte(lead, 1'b0);
        for (int unsigned i = 1; i < lead_length(lead); i++) add_byte(rand_cont(), rand_eot());
      end else if (pick < 90) begin
        // truncated sequence: the next byte may break it
        lead = 8'($urandom_range(Lead3Lo, Lead4Hi));
        conts = $urandom_range(lead_length(lead) - 2);
        add_byte(lead, rand_eot());
        for (int unsigned i = 0; i < conts; i++) add_byte(rand_cont(), rand_eot());
      end else begin
        add_byte(8'($urandom_range(255)), rand_eot());
      end
    end
  endtask

  task automatic drain();
    while (bytes_taken != bytes_queued || cp_expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed text: boundaries of each lead class, stray and broken bytes
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hC0, 1'b0);
    add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hDF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hF4, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hF5, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'hE0, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hE1, 1'b0); add_byte(8'h80, 1'b1);
    add_byte(8'h7F, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 84; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 84; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      add_random_text(20);
      drain();
    end

    repeat (DrainCycles) @(negedge clk_i);
    $display("tb: %0d bytes sent over 4 idle/stall phases, %0d ended a text",
             bytes_taken, texts_ended);
    $display("tb: %0d codepoint results checked, %0d errors", results_seen, error_cnt);
    if (error_cnt == 0 && cp_expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
